@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every rising clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/apvt_pkg.sv @@
// ----------------------------------------------------------------------------
// apvt_pkg
// widths, register indexes and reset values of the affine point transform
// ----------------------------------------------------------------------------
package apvt_pkg;

  localparam int COORD_BITS     = 24;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_BITS      = 16;
  localparam int NUM_AXES       = 3;

  localparam int ROW_W  = NUM_AXES * COEF_BITS;
  localparam int CFG_W  = ROW_W;
  localparam int IDX_W  = 3;
  localparam int PROD_W = COEF_BITS + COORD_BITS;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - COEF_FRAC_BITS;
  localparam int TR_W   = RND_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [RND_W-1:0]      rnd_t;
  typedef logic signed [TR_W-1:0]       tr_t;
  typedef logic        [ROW_W-1:0]      row_t;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROT_X   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROT_Y   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ROT_Z   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SHIFT_X = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_SHIFT_Y = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SHIFT_Z = IDX_W'(5);

  // operation codes
  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // identity matrix rows
  localparam row_t ROT_X_RST = ROW_W'(1) << COEF_FRAC_BITS;
  localparam row_t ROT_Y_RST = ROW_W'(1) << (COEF_FRAC_BITS + COEF_BITS);
  localparam row_t ROT_Z_RST = ROW_W'(1) << (COEF_FRAC_BITS + 2 * COEF_BITS);

  localparam sum_t   RND_HALF  = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

endpackage

@@ rtl/affine_point_vector_transform_top.sv @@
// ----------------------------------------------------------------------------
// affine_point_vector_transform_top
// pipeline: request accept to out_valid_o passes three register stages (multiply,
//   row sum and round, translate and saturate)
// throughput: one request per cycle; an output stall holds the three stages,
//   and in_ready_o drops only once every stage is full
// reset: matrix goes to identity, translation to zero, pipeline empties
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_point_vector_transform_top
  import apvt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  coord_t                in_x_i,
  input  coord_t                in_y_i,
  input  coord_t                in_z_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output coord_t                out_x_o,
  output coord_t                out_y_o,
  output coord_t                out_z_o,
  output logic                  overflow_o
);

  row_t   rot_q   [NUM_AXES];
  coord_t shift_q [NUM_AXES];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= ROT_X_RST;
      rot_q[1]   <= ROT_Y_RST;
      rot_q[2]   <= ROT_Z_RST;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROT_X:   rot_q[0]   <= cfg_wdata_i;
        REG_ROT_Y:   rot_q[1]   <= cfg_wdata_i;
        REG_ROT_Z:   rot_q[2]   <= cfg_wdata_i;
        REG_SHIFT_X: shift_q[0] <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SHIFT_Y: shift_q[1] <= cfg_wdata_i[COORD_BITS-1:0];
        REG_SHIFT_Z: shift_q[2] <= cfg_wdata_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: nine coefficient products
  coord_t coord_in [NUM_AXES];
  prod_t  prod_d   [NUM_AXES][NUM_AXES];
  prod_t  prod_q   [NUM_AXES][NUM_AXES];
  logic   op1_q;

  assign coord_in[0] = in_x_i;
  assign coord_in[1] = in_y_i;
  assign coord_in[2] = in_z_i;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        prod_d[r][c] = coef_t'(rot_q[r][c*COEF_BITS +: COEF_BITS]) * coord_in[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      prod_q <= prod_d;
      op1_q  <= operation_i;
    end
  end

  // stage 2: row sums, round to nearest with ties up
  sum_t sum_d [NUM_AXES];
  rnd_t rnd_q [NUM_AXES];
  logic op2_q;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      sum_d[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2])
               + RND_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        rnd_q[r] <= $signed(sum_d[r][SUM_W-1:COEF_FRAC_BITS]);
      end
      op2_q <= op1_q;
    end
  end

  // stage 3: translation (points only) and saturation
  tr_t    tr_d  [NUM_AXES];
  coord_t sat_d [NUM_AXES];
  logic   [NUM_AXES-1:0] clip_d;
  coord_t res_q [NUM_AXES];
  logic   ovf_q;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      tr_d[r] = TR_W'(rnd_q[r]) + ((op2_q == OP_POINT) ? TR_W'(shift_q[r]) : '0);
      if (tr_d[r] > TR_W'(COORD_MAX)) begin
        sat_d[r]  = COORD_MAX;
        clip_d[r] = 1'b1;
      end else if (tr_d[r] < TR_W'(COORD_MIN)) begin
        sat_d[r]  = COORD_MIN;
        clip_d[r] = 1'b1;
      end else begin
        sat_d[r]  = tr_d[r][COORD_BITS-1:0];
        clip_d[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      res_q <= sat_d;
      ovf_q <= |clip_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign overflow_o  = ovf_q;

  `ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, in_valid_i && in_ready_o, v1_q,
    "accepted request did not reach stage 1")

  `ASSERT_NEXT(a_s2_moves_out, clk_i, rst_ni, v2_q && en3, out_valid_o,
    "stage 2 result lost on advance")

  `ASSERT_AT(a_full_stall_blocks, clk_i, rst_ni,
    !(v1_q && v2_q && v3_q && !out_ready_i) || !in_ready_o,
    "request taken while pipeline full and stalled")

  `ASSERT_AT(a_ovf_at_bound, clk_i, rst_ni,
    !(out_valid_o && overflow_o) || out_x_o == COORD_MAX || out_x_o == COORD_MIN
      || out_y_o == COORD_MAX || out_y_o == COORD_MIN
      || out_z_o == COORD_MAX || out_z_o == COORD_MIN,
    "overflow flagged with no component at a bound")

endmodule

@@ tb/sv/affine_point_vector_transform_top_tb.sv @@
// ----------------------------------------------------------------------------
// affine_point_vector_transform_top_tb
// self-checking bench for the affine point / direction transform: a predictor
// keeps its own copy of the matrix rows and translation, works out each
// transformed coordinate with rounding and saturation, and a monitor compares
// every result with the oldest prediction under random gaps on both sides
// ----------------------------------------------------------------------------
module affine_point_vector_transform_top_tb;
  import apvt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // index codes the block does not decode
  localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(7);

  typedef struct {
    logic   op;
    coord_t x;
    coord_t y;
    coord_t z;
  } point_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   ovf;
  } point_res_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             operation_i = OP_POINT;
  coord_t           in_x_i      = '0;
  coord_t           in_y_i      = '0;
  coord_t           in_z_i      = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  coord_t           out_x_o;
  coord_t           out_y_o;
  coord_t           out_z_o;
  logic             overflow_o;

  affine_point_vector_transform_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .overflow_o  (overflow_o)
  );

  // predictor copy of the registers
  row_t   mat_rows [3] = '{ROT_X_RST, ROT_Y_RST, ROT_Z_RST};
  coord_t shift_vec[3] = '{'0, '0, '0};

  point_req_t point_reqs[$];
  point_res_t expected_points[$];
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  int         req_gap        = 0;
  int         ready_stall    = 0;
  bit         req_taken      = 1'b0;
  bit         in_no_idle     = 1'b0;
  bit         out_no_idle    = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic point_res_t transform_point(point_req_t req);
    point_res_t res;
    longint     coord[3];
    longint     acc;
    longint     r;
    coord_t     comp[3];
    coef_t      coef;
    res.ovf  = 1'b0;
    coord[0] = req.x;
    coord[1] = req.y;
    coord[2] = req.z;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        coef = coef_t'(mat_rows[i][j*COEF_BITS +: COEF_BITS]);
        acc += longint'(coef) * coord[j];
      end
      // nearest, ties toward plus infinity
      r = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (req.op == OP_POINT) begin
        r += longint'(shift_vec[i]);
      end
      if (r > longint'(COORD_MAX)) begin
        r = longint'(COORD_MAX);
        res.ovf = 1'b1;
      end else if (r < longint'(COORD_MIN)) begin
        r = longint'(COORD_MIN);
        res.ovf = 1'b1;
      end
      comp[i] = coord_t'(r);
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic coord_t rand_coord();
    int m;
    m = $urandom_range(0, 9);
    if (m < 5) begin
      return coord_t'($urandom);
    end else if (m < 7) begin
      return coord_t'($urandom_range(0, 2046)) - coord_t'(1023);
    end else if (m < 9) begin
      return coord_t'($urandom_range(0, 131071)) - coord_t'(65536);
    end
    case ($urandom_range(0, 3))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t  row;
    coef_t coef;
    int    m;
    for (int j = 0; j < 3; j++) begin
      m = $urandom_range(0, 9);
      if (m < 5) begin
        coef = coef_t'($urandom);
      end else if (m < 9) begin
        coef = coef_t'($urandom_range(0, 32768)) - coef_t'(16384);
      end else begin
        case ($urandom_range(0, 3))
          0: coef = 16'sh7fff;
          1: coef = 16'sh8000;
          2: coef = 16'sh0000;
          default: coef = 16'sh4000;
        endcase
      end
      row[j*COEF_BITS +: COEF_BITS] = coef;
    end
    return row;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // write one register while the pipeline is empty and mirror it in the predictor
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_ROT_X:   mat_rows[0]  = data[ROW_W-1:0];
      REG_ROT_Y:   mat_rows[1]  = data[ROW_W-1:0];
      REG_ROT_Z:   mat_rows[2]  = data[ROW_W-1:0];
      REG_SHIFT_X: shift_vec[0] = coord_t'(data[COORD_BITS-1:0]);
      REG_SHIFT_Y: shift_vec[1] = coord_t'(data[COORD_BITS-1:0]);
      REG_SHIFT_Z: shift_vec[2] = coord_t'(data[COORD_BITS-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_point(logic op, coord_t x, coord_t y, coord_t z);
    point_req_t req;
    req.op = op;
    req.x  = x;
    req.y  = y;
    req.z  = z;
    point_reqs.push_back(req);
  endtask

  task automatic wait_drained();
    while (point_reqs.size() != 0 || in_valid_i || expected_points.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // request side: predict on accept
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      point_req_t req;
      req.op = operation_i;
      req.x  = in_x_i;
      req.y  = in_y_i;
      req.z  = in_z_i;
      expected_points.push_back(transform_point(req));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        in_valid_i <= 1'b0;
      end else if (point_reqs.size() != 0) begin
        point_req_t req;
        req = point_reqs.pop_front();
        operation_i <= req.op;
        in_x_i      <= req.x;
        in_y_i      <= req.y;
        in_z_i      <= req.z;
        in_valid_i  <= 1'b1;
        req_gap     = pick_gap(in_no_idle);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_stall > 0) begin
        ready_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        ready_stall = pick_gap(out_no_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected x=%0d y=%0d z=%0d",
                                  out_x_o, out_y_o, out_z_o));
      end else begin
        point_res_t want;
        want = expected_points.pop_front();
        if (out_x_o !== want.x) begin
          report_mismatch($sformatf("out_x got %0d want %0d", out_x_o, want.x));
        end
        if (out_y_o !== want.y) begin
          report_mismatch($sformatf("out_y got %0d want %0d", out_y_o, want.y));
        end
        if (out_z_o !== want.z) begin
          report_mismatch($sformatf("out_z got %0d want %0d", out_z_o, want.z));
        end
        if (overflow_o !== want.ovf) begin
          report_mismatch($sformatf("overflow got %b want %b", overflow_o, want.ovf));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // identity after reset
    queue_point(OP_POINT,  COORD_MAX, COORD_MIN, '0);
    queue_point(OP_VECTOR, '1, 24'sd1, COORD_MAX);
    queue_point(OP_POINT,  COORD_MIN, COORD_MAX, '1);
    queue_point(OP_VECTOR, '0, '0, '0);
    wait_drained();

    // largest coefficients, largest shift with junk above the shift width
    cfg_write(REG_ROT_X, {3{16'h7fff}});
    cfg_write(REG_ROT_Y, {3{16'h7fff}});
    cfg_write(REG_ROT_Z, {3{16'h7fff}});
    cfg_write(REG_SHIFT_X, {24'hffffff, COORD_MAX});
    cfg_write(REG_SHIFT_Y, {24'hffffff, COORD_MAX});
    cfg_write(REG_SHIFT_Z, {24'hffffff, COORD_MAX});
    queue_point(OP_POINT,  COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(OP_VECTOR, COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(OP_POINT,  '0, '0, '0);
    queue_point(OP_VECTOR, 24'sd1, '0, '0);
    wait_drained();

    // most negative coefficients and shift
    cfg_write(REG_ROT_X, {3{16'h8000}});
    cfg_write(REG_ROT_Y, {3{16'h8000}});
    cfg_write(REG_ROT_Z, {3{16'h8000}});
    cfg_write(REG_SHIFT_X, {24'h0, COORD_MIN});
    cfg_write(REG_SHIFT_Y, {24'h0, COORD_MIN});
    cfg_write(REG_SHIFT_Z, {24'h0, COORD_MIN});
    queue_point(OP_POINT,  COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(OP_POINT,  '0, '0, '0);
    queue_point(OP_VECTOR, COORD_MAX, '0, '0);
    queue_point(OP_VECTOR, '1, '1, '1);
    wait_drained();

    // half coefficients hit the rounding ties; undecoded indexes change nothing
    cfg_write(REG_ROT_X, {16'h0, 16'h0, 16'h2000});
    cfg_write(REG_ROT_Y, {16'h0, 16'h0, 16'he000});
    cfg_write(REG_ROT_Z, {3{16'h2000}});
    cfg_write(REG_SHIFT_X, '0);
    cfg_write(REG_SHIFT_Y, '0);
    cfg_write(REG_SHIFT_Z, '0);
    cfg_write(REG_SPARE_A, '1);
    cfg_write(REG_SPARE_B, '1);
    queue_point(OP_VECTOR, 24'sd1, '0, '0);
    queue_point(OP_VECTOR, -24'sd1, '0, '0);
    queue_point(OP_VECTOR, 24'sd3, '0, '0);
    queue_point(OP_VECTOR, -24'sd3, '0, '0);
    queue_point(OP_POINT,  24'sd1, 24'sd1, 24'sd1);
    wait_drained();

    // translation alone pushes past the range
    cfg_write(REG_ROT_X, ROT_X_RST);
    cfg_write(REG_ROT_Y, ROT_Y_RST);
    cfg_write(REG_ROT_Z, ROT_Z_RST);
    cfg_write(REG_SHIFT_X, CFG_W'(COORD_MAX));
    cfg_write(REG_SHIFT_Y, CFG_W'(COORD_MIN));
    cfg_write(REG_SHIFT_Z, '1);
    queue_point(OP_POINT,  24'sd1, -24'sd1, COORD_MIN);
    queue_point(OP_VECTOR, 24'sd1, -24'sd1, COORD_MIN);
    queue_point(OP_POINT,  -24'sd1, 24'sd1, '0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      cfg_write(REG_ROT_X, rand_row());
      cfg_write(REG_ROT_Y, rand_row());
      cfg_write(REG_ROT_Z, rand_row());
      cfg_write(REG_SHIFT_X, CFG_W'({$urandom, $urandom}));
      cfg_write(REG_SHIFT_Y, CFG_W'({$urandom, $urandom}));
      cfg_write(REG_SHIFT_Z, CFG_W'({$urandom, $urandom}));
      if ($urandom_range(0, 2) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_W'({$urandom, $urandom}));
      end
      n = $urandom_range(55, 70);
      for (int k = 0; k < n; k++) begin
        queue_point($urandom_range(0, 1) ? OP_VECTOR : OP_POINT,
                    rand_coord(), rand_coord(), rand_coord());
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/apvt_pkg.sv
rtl/affine_point_vector_transform_top.sv
tb/sv/affine_point_vector_transform_top_tb.sv
